@@ rtl/dt2ep_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dt2ep_pkg: shared constants for the civil date to epoch seconds converter
// Calendar constants, the reciprocal used for divide-by-100 and the
// cumulative month table.
// ----------------------------------------------------------------------------
package dt2ep_pkg;

  localparam int unsigned YearW    = 14;
  localparam int unsigned DaysW    = 23;  // day count up to year 16383
  localparam int unsigned HmsW     = 17;  // seconds within a day
  localparam int unsigned TotalW   = 40;  // unsaturated second count
  localparam int unsigned SecW     = 38;  // result width

  localparam logic [YearW-1:0]  EpochYear   = 14'd1970;
  // Leap years in 1..1969: 492 - 19 + 4
  localparam logic [DaysW-1:0]  EpochLeaps  = 23'd477;
  localparam logic [DaysW-1:0]  DaysPerYear = 23'd365;
  localparam logic [TotalW-1:0] SecsPerDay  = 40'd86400;
  localparam logic [HmsW-1:0]   SecsPerHour = 17'd3600;
  localparam logic [HmsW-1:0]   SecsPerMin  = 17'd60;

  // floor(n / 100) == (n * 5243) >> 19 for every n below 43690
  localparam int unsigned       Div100Shift = 19;
  localparam int unsigned       Div100ProdW = 27;
  localparam logic [Div100ProdW-1:0] Div100Mult = 27'd5243;
  localparam int unsigned       CentW       = 8;   // year / 100 fits in 8 bits
  localparam logic [YearW-1:0]  Hundred     = 14'd100;

  localparam logic [SecW-1:0]   SecMax      = {SecW{1'b1}};

  // Days before the first of the month in a common year.
  function automatic logic [8:0] days_before_month(input logic [3:0] month);
    logic [8:0] d;
    unique case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

@@ rtl/civil_datetime_to_epoch_seconds_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// civil_datetime_to_epoch_seconds_core: Gregorian date/time to Unix seconds
// Four-stage stalling pipeline from a civil date and time to the count of
// seconds since 1970-01-01 00:00:00.
// ----------------------------------------------------------------------------
// Converts one Gregorian date and time per beat into seconds since the Unix
// epoch. Throughput is one beat per clock while the output is not stalled.
// An accepted beat moves through the stage 1, 2 and 3 registers into the
// output register, where it stays until the consumer takes it. The
// pipeline is: (1) range checks and the two divide-by-100 reciprocal
// multiplies, (2) leap count, day count and seconds within the day, (3) the
// days * 86400 multiply plus time of day, (4) zeroing of invalid beats,
// saturation and the output register. Any year before 1970, month outside
// 1..12, day of zero, hour of 24 or more, or minute/second of 60 or more
// gives invalid_o = 1 with zero seconds. The day is not checked against the
// month length, so days past the end of a month roll into the next. Counts
// beyond 38 bits saturate to all ones. A stall on the output back-pressures
// stage by stage; a stage with no valid beat takes a new one even while
// later stages hold.
// ----------------------------------------------------------------------------
module civil_datetime_to_epoch_seconds_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [13:0] year_i,
  input  wire logic [3:0]  month_i,
  input  wire logic [4:0]  day_i,
  input  wire logic [4:0]  hour_i,
  input  wire logic [5:0]  minute_i,
  input  wire logic [5:0]  second_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             invalid_o,
  output logic [37:0]      epoch_seconds_o
);

  // Advance enables: a stage loads when it is empty or its beat moves on.
  logic adv1, adv2, adv3, adv4;
  logic v1_q, v2_q, v3_q;

  assign adv4 = !out_valid_o || !out_stall_i;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_stall_o = !adv1;

  // --------------------------------------------------------------------------
  // Stage 1: range checks and divide-by-100 of year and year - 1
  // --------------------------------------------------------------------------
  logic                                    bad_d;
  logic [dt2ep_pkg::YearW-1:0]             year_m1;
  logic [dt2ep_pkg::Div100ProdW-1:0]       yprod, nprod;

  assign bad_d = (year_i < dt2ep_pkg::EpochYear) || (month_i == 4'd0) ||
                 (month_i > 4'd12) || (day_i == 5'd0) || (hour_i >= 5'd24) ||
                 (minute_i >= 6'd60) || (second_i >= 6'd60);
  assign year_m1 = year_i - 14'd1;
  assign yprod = dt2ep_pkg::Div100ProdW'(year_i) * dt2ep_pkg::Div100Mult;
  assign nprod = dt2ep_pkg::Div100ProdW'(year_m1) * dt2ep_pkg::Div100Mult;

  logic                          bad1_q;
  logic [dt2ep_pkg::YearW-1:0]   year1_q;
  logic [3:0]                    month1_q;
  logic [4:0]                    day1_q, hour1_q;
  logic [5:0]                    min1_q, sec1_q;
  logic [dt2ep_pkg::CentW-1:0]   ycent1_q, ncent1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      bad1_q   <= bad_d;
      year1_q  <= year_i;
      month1_q <= month_i;
      day1_q   <= day_i;
      hour1_q  <= hour_i;
      min1_q   <= minute_i;
      sec1_q   <= second_i;
      ycent1_q <= yprod[dt2ep_pkg::Div100Shift +: dt2ep_pkg::CentW];
      ncent1_q <= nprod[dt2ep_pkg::Div100Shift +: dt2ep_pkg::CentW];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: leap count, day count and seconds within the day
  // --------------------------------------------------------------------------
  logic [dt2ep_pkg::YearW-1:0] n1, year_off;
  logic [dt2ep_pkg::YearW-1:0] cent_x100;
  logic                        is_leap;
  logic [dt2ep_pkg::DaysW-1:0] leaps, days_d;
  logic [dt2ep_pkg::HmsW-1:0]  hms_d;

  assign n1        = year1_q - 14'd1;
  assign year_off  = year1_q - dt2ep_pkg::EpochYear;
  assign cent_x100 = dt2ep_pkg::YearW'(ycent1_q) * dt2ep_pkg::Hundred;
  // Divisible by 4, and either not a century or a century divisible by 400.
  assign is_leap   = (year1_q[1:0] == 2'b00) &&
                     ((year1_q != cent_x100) || (ycent1_q[1:0] == 2'b00));
  assign leaps     = dt2ep_pkg::DaysW'(n1 >> 2) - dt2ep_pkg::DaysW'(ncent1_q) +
                     dt2ep_pkg::DaysW'(ncent1_q >> 2) - dt2ep_pkg::EpochLeaps;
  assign days_d    = dt2ep_pkg::DaysW'(year_off) * dt2ep_pkg::DaysPerYear + leaps +
                     dt2ep_pkg::DaysW'(dt2ep_pkg::days_before_month(month1_q)) +
                     dt2ep_pkg::DaysW'(is_leap && (month1_q > 4'd2)) +
                     dt2ep_pkg::DaysW'(day1_q) - 23'd1;
  assign hms_d     = dt2ep_pkg::HmsW'(hour1_q) * dt2ep_pkg::SecsPerHour +
                     dt2ep_pkg::HmsW'(min1_q) * dt2ep_pkg::SecsPerMin +
                     dt2ep_pkg::HmsW'(sec1_q);

  logic                        bad2_q;
  logic [dt2ep_pkg::DaysW-1:0] days2_q;
  logic [dt2ep_pkg::HmsW-1:0]  hms2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      bad2_q  <= bad1_q;
      days2_q <= days_d;
      hms2_q  <= hms_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: scale days to seconds and add the time of day
  // --------------------------------------------------------------------------
  logic [dt2ep_pkg::TotalW-1:0] total_d;
  logic                         bad3_q;
  logic [dt2ep_pkg::TotalW-1:0] total3_q;

  assign total_d = dt2ep_pkg::TotalW'(days2_q) * dt2ep_pkg::SecsPerDay +
                   dt2ep_pkg::TotalW'(hms2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      bad3_q   <= bad2_q;
      total3_q <= total_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: zero invalid beats, saturate at 38 bits, drive the output
  // --------------------------------------------------------------------------
  logic [dt2ep_pkg::SecW-1:0] secs_d;

  always_comb begin
    priority if (bad3_q) begin
      secs_d = '0;
    end else if (total3_q > dt2ep_pkg::TotalW'(dt2ep_pkg::SecMax)) begin
      secs_d = dt2ep_pkg::SecMax;
    end else begin
      secs_d = total3_q[dt2ep_pkg::SecW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv4) begin
      out_valid_o <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      invalid_o       <= bad3_q;
      epoch_seconds_o <= secs_d;
    end
  end

`ifndef SYNTHESIS
  // An invalid result always carries zero seconds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && invalid_o) |-> (epoch_seconds_o == '0))
    else $error("invalid result with nonzero seconds");

  // The input is stalled only while stage 1 holds a beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v1_q)
    else $error("input stalled with stage 1 empty");

  // A beat in stage 3 that cannot move stays put, unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !adv4) |=> (v3_q && $stable(total3_q) && $stable(bad3_q)))
    else $error("stage 3 beat lost or changed while held");

  // A beat in stage 1 that cannot move stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !adv2) |=> (v1_q && $stable(year1_q)))
    else $error("stage 1 beat lost or changed while held");
`endif

endmodule

`default_nettype wire

@@ sim/civil_datetime_to_epoch_seconds_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// civil_datetime_to_epoch_seconds_core_test: date to epoch seconds checker
// Sends dates through the converter with random idle bursts on both sides.
// Each result is checked against an in-bench calendar computation, in order.
// ----------------------------------------------------------------------------
module civil_datetime_to_epoch_seconds_core_test;

  localparam int unsigned SecW          = dt2ep_pkg::SecW;
  localparam int unsigned FirstYear     = 1970;
  localparam int unsigned RandomDates   = 850;
  localparam int unsigned QuietTail     = 80;   // beats at the end with no idling
  localparam int unsigned WatchdogLimit = 2000; // cycles with no beat on either side
  localparam int unsigned SettleCycles  = 12;   // latency plus margin at the end
  localparam int unsigned MaxReported   = 10;

  typedef struct {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    bit          drain;   // hold this beat until every result is back
  } civil_date_t;

  typedef struct packed {
    logic            invalid;
    logic [SecW-1:0] seconds;
  } epoch_result_t;

  // Clock, reset and ports; every input starts at a known value.
  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              in_valid_i      = 1'b0;
  logic              in_stall_o;
  logic [13:0]       year_i          = '0;
  logic [3:0]        month_i         = '0;
  logic [4:0]        day_i           = '0;
  logic [4:0]        hour_i          = '0;
  logic [5:0]        minute_i        = '0;
  logic [5:0]        second_i        = '0;
  logic              out_valid_o;
  logic              out_stall_i     = 1'b0;
  logic              invalid_o;
  logic [SecW-1:0]   epoch_seconds_o;

  civil_date_t       date_queue[$];
  epoch_result_t     epoch_expected[$];

  int unsigned       total_dates;
  int unsigned       dates_sent;
  int unsigned       mismatch_count;
  int unsigned       quiet_cycles;
  bit                timed_out;
  logic              in_accepted;
  int unsigned       send_gap;
  int unsigned       recv_gap;

  civil_datetime_to_epoch_seconds_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .year_i         (year_i),
    .month_i        (month_i),
    .day_i          (day_i),
    .hour_i         (hour_i),
    .minute_i       (minute_i),
    .second_i       (second_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .invalid_o      (invalid_o),
    .epoch_seconds_o(epoch_seconds_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Leap years in 1..n.
  function automatic logic [63:0] leaps_upto(input logic [63:0] n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  // Days before the first of a month in a common year.
  function automatic logic [63:0] month_offset(input logic [3:0] month);
    case (month)
      4'd2:    return 64'd31;
      4'd3:    return 64'd59;
      4'd4:    return 64'd90;
      4'd5:    return 64'd120;
      4'd6:    return 64'd151;
      4'd7:    return 64'd181;
      4'd8:    return 64'd212;
      4'd9:    return 64'd243;
      4'd10:   return 64'd273;
      4'd11:   return 64'd304;
      4'd12:   return 64'd334;
      default: return 64'd0;
    endcase
  endfunction

  function automatic epoch_result_t civil_to_epoch(input logic [13:0] year,
                                                   input logic [3:0]  month,
                                                   input logic [4:0]  day,
                                                   input logic [4:0]  hour,
                                                   input logic [5:0]  minute,
                                                   input logic [5:0]  second);
    epoch_result_t res;
    logic [63:0]   y;
    logic [63:0]   days;
    logic [63:0]   secs;
    logic          leap;
    y = year;
    res.invalid = (year < FirstYear) || (month == 4'd0) || (month > 4'd12) ||
                  (day == 5'd0) || (hour >= 5'd24) || (minute >= 6'd60) ||
                  (second >= 6'd60);
    if (res.invalid) begin
      res.seconds = '0;
    end else begin
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      days = 365 * (y - FirstYear) + leaps_upto(y - 1) - leaps_upto(FirstYear - 1);
      days = days + month_offset(month);
      if (month > 4'd2 && leap) begin
        days = days + 1;
      end
      // The day is not checked against the month, so late days roll onward.
      days = days + day - 1;
      secs = days * 86400 + hour * 3600 + minute * 60 + second;
      if (secs > dt2ep_pkg::SecMax) begin
        secs = dt2ep_pkg::SecMax;
      end
      res.seconds = secs[SecW-1:0];
    end
    return res;
  endfunction

  task automatic queue_date(input int unsigned year, input int unsigned month,
                            input int unsigned day, input int unsigned hour,
                            input int unsigned minute, input int unsigned second,
                            input bit drain);
    civil_date_t d;
    d.year   = year[13:0];
    d.month  = month[3:0];
    d.day    = day[4:0];
    d.hour   = hour[4:0];
    d.minute = minute[5:0];
    d.second = second[5:0];
    d.drain  = drain;
    date_queue.push_back(d);
  endtask

  // Allow idle bursts in 140 of every 200 beats, never in the closing stretch.
  function automatic bit idling_allowed();
    return (dates_sent + QuietTail < total_dates) && ((dates_sent % 200) < 140);
  endfunction

  // Sample both handshakes at the rising edge: check results, then predict.
  always @(posedge clk_i) begin : watch_beats
    epoch_result_t want;
    bit            in_fire;
    bit            out_fire;
    in_fire  = rst_ni && (in_valid_i === 1'b1) && (in_stall_o === 1'b0);
    out_fire = rst_ni && (out_valid_o === 1'b1) && (out_stall_i === 1'b0);
    in_accepted <= in_fire;
    if (out_fire) begin
      if (epoch_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReported) begin
          $display("unexpected result beat: invalid=%0b seconds=%0d",
                   invalid_o, epoch_seconds_o);
        end
      end else begin
        want = epoch_expected.pop_front();
        if (invalid_o !== want.invalid || epoch_seconds_o !== want.seconds) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported) begin
            $display("mismatch: expected invalid=%0b seconds=%0d, got invalid=%0b seconds=%0d",
                     want.invalid, want.seconds, invalid_o, epoch_seconds_o);
          end
        end
      end
    end
    if (in_fire) begin
      epoch_expected.push_back(civil_to_epoch(year_i, month_i, day_i, hour_i,
                                              minute_i, second_i));
      dates_sent++;
    end
    // Count cycles with no beat on either side; stop a hung run.
    if (rst_ni) begin
      if (in_fire || out_fire) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          timed_out = 1'b1;
        end
      end
    end
  end

  // Drive the input channel at the falling edge from the pending queue.
  always @(negedge clk_i) begin : drive_dates
    civil_date_t d;
    logic        valid_next;
    bit          load;
    valid_next = in_valid_i;
    load       = 1'b0;
    if (rst_ni && !(in_valid_i && !in_accepted)) begin
      // Previous beat taken (or none pending): pick what goes out next.
      valid_next = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (date_queue.size() != 0) begin
        if (date_queue[0].drain && epoch_expected.size() != 0) begin
          // Hold off until the pipeline has emptied.
        end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 11);
        end else begin
          d          = date_queue.pop_front();
          valid_next = 1'b1;
          load       = 1'b1;
        end
      end
    end
    in_valid_i <= valid_next;
    if (load) begin
      year_i   <= d.year;
      month_i  <= d.month;
      day_i    <= d.day;
      hour_i   <= d.hour;
      minute_i <= d.minute;
      second_i <= d.second;
    end
  end

  // Stall the output channel in random bursts.
  always @(negedge clk_i) begin : drive_stall
    logic stall_next;
    stall_next = 1'b0;
    if (rst_ni) begin
      if (recv_gap > 0) begin
        recv_gap--;
        stall_next = 1'b1;
      end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
        recv_gap   = $urandom_range(0, 11);
        stall_next = 1'b1;
      end
    end
    out_stall_i <= stall_next;
  end

  initial begin : run_dates
    int unsigned pick;
    int unsigned yr;
    civil_date_t d;
    dates_sent     = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    timed_out      = 1'b0;
    send_gap       = 0;
    recv_gap       = 0;
    in_accepted    = 1'b0;

    // Directed: epoch, leap rules, month rollover, range limits, saturation.
    queue_date(1970, 1, 1, 0, 0, 0, 1'b0);
    queue_date(1970, 12, 31, 23, 59, 59, 1'b0);
    queue_date(2000, 2, 29, 12, 30, 30, 1'b0);
    queue_date(2000, 3, 1, 0, 0, 0, 1'b0);
    queue_date(2100, 3, 1, 0, 0, 0, 1'b0);
    queue_date(2024, 3, 1, 0, 0, 0, 1'b0);
    queue_date(2023, 2, 31, 0, 0, 0, 1'b0);
    queue_date(2024, 2, 31, 0, 0, 0, 1'b0);
    queue_date(2023, 4, 31, 23, 59, 59, 1'b0);
    queue_date(2038, 1, 19, 3, 14, 8, 1'b0);
    queue_date(9999, 12, 31, 23, 59, 59, 1'b0);
    queue_date(10680, 6, 15, 0, 0, 0, 1'b0);
    queue_date(16383, 12, 31, 23, 59, 59, 1'b0);
    queue_date(1969, 12, 31, 23, 59, 59, 1'b0);
    queue_date(0, 1, 1, 0, 0, 0, 1'b0);
    queue_date(2020, 0, 1, 0, 0, 0, 1'b0);
    queue_date(2020, 13, 1, 0, 0, 0, 1'b0);
    queue_date(2020, 15, 31, 31, 63, 63, 1'b0);
    queue_date(2020, 6, 0, 0, 0, 0, 1'b0);
    queue_date(2020, 6, 1, 24, 0, 0, 1'b0);
    queue_date(2020, 6, 1, 31, 0, 0, 1'b0);
    queue_date(2020, 6, 1, 0, 60, 0, 1'b0);
    queue_date(2020, 6, 1, 0, 63, 0, 1'b0);
    queue_date(2020, 6, 1, 0, 0, 60, 1'b0);
    queue_date(2020, 6, 1, 0, 0, 63, 1'b0);

    // Random: mostly well-formed dates, some with one field broken, some noise.
    for (int i = 0; i < RandomDates; i++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3, 4: yr = $urandom_range(FirstYear, 2500);
        5, 6:          yr = $urandom_range(FirstYear, 9999);
        7:             yr = $urandom_range(9999, 16383);
        default:       yr = $urandom_range(FirstYear, 16383);
      endcase
      d.year   = yr[13:0];
      d.month  = 4'($urandom_range(1, 12));
      d.day    = 5'($urandom_range(1, 31));
      d.hour   = 5'($urandom_range(0, 23));
      d.minute = 6'($urandom_range(0, 59));
      d.second = 6'($urandom_range(0, 59));
      d.drain  = (i == 250) || (i == 560);
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
        // Noise: every field from raw random bits.
        d.year   = 14'($urandom);
        d.month  = 4'($urandom);
        d.day    = 5'($urandom);
        d.hour   = 5'($urandom);
        d.minute = 6'($urandom);
        d.second = 6'($urandom);
      end else if (pick < 5) begin
        // Break one field by putting it outside its range.
        case ($urandom_range(0, 5))
          0:       d.year   = 14'($urandom_range(0, FirstYear - 1));
          1:       d.month  = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
          2:       d.day    = 5'd0;
          3:       d.hour   = 5'($urandom_range(24, 31));
          4:       d.minute = 6'($urandom_range(60, 63));
          default: d.second = 6'($urandom_range(60, 63));
        endcase
      end
      date_queue.push_back(d);
    end
    total_dates = date_queue.size();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Run until every date is taken and every result is back.
    while (!timed_out && (date_queue.size() != 0 || in_valid_i ||
                          epoch_expected.size() != 0)) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (epoch_expected.size() != 0) begin
      mismatch_count++;
    end

    if (!timed_out && mismatch_count == 0) begin
      $display("civil_datetime_to_epoch_seconds_core verification clean");
    end else begin
      $display("civil_datetime_to_epoch_seconds_core verification failed");
    end
    $finish;
  end

endmodule
